// ----- sv/ridf_pkg.sv -----
// shared types and constants of the recent-id duplicate filter
package ridf_pkg;

  // width of the identifier port
  localparam int MSG_ID_W = 64;

  // request kinds carried on req_type
  typedef enum logic {
    REQ_CHECK = 1'b0,
    REQ_ADD   = 1'b1
  } req_type_e;

endpackage

// ----- sv/recent_id_duplicate_filter.sv -----
// top level of the recent-id duplicate filter: request control and ring scan
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i / in_ready_o req_type_i, msg_id_i
//   out      output     out_valid_o/out_ready_i is_duplicate_o
//
// an add writes the ring at the write pointer on accept
// a check scans the N stored entries through the single read port of the ring,
// one entry per cycle, stopping at a match
// reset clears the write pointer and the filled mark; the ring needs no clearing
// a finished check whose result cannot leave waits in a holding register and
// holds off the input; a result waiting only in the output register stalls nothing
module recent_id_duplicate_filter #(
  parameter int WINDOW_DEPTH = 64,
  parameter int ID_BYTES     = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [ridf_pkg::MSG_ID_W-1:0] msg_id_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          is_duplicate_o
);
  import ridf_pkg::*;

  localparam int ID_W  = 8 * ID_BYTES;
  localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_e;

  state_e            state_q, state_d;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic              ring_full_q, ring_full_d;
  logic [CNT_W-1:0]  limit_q, limit_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic              rd_valid_q, rd_valid_d;
  logic              res_q, res_d;
  logic              out_valid_q, out_valid_d;
  logic              out_dup_q, out_dup_d;
  logic [ID_W-1:0]   key_q;

  logic              accept;
  logic              do_add;
  logic              do_check;
  logic              match;
  logic              issued_all;
  logic              issue;
  logic              finish;
  logic              out_free;
  logic              wrap;
  logic [ID_W-1:0]   rd_data;

  // ring memory; adds only happen in idle, so a write never meets a scan read
  ridf_ring #(
    .DEPTH  (WINDOW_DEPTH),
    .WIDTH  (ID_W),
    .ADDR_W (PTR_W)
  ) u_ring (
    .clk_i     (clk_i),
    .wr_en_i   (do_add),
    .wr_addr_i (wr_ptr_q),
    .wr_data_i (msg_id_i[ID_W-1:0]),
    .rd_en_i   (issue),
    .rd_addr_i (idx_q[PTR_W-1:0]),
    .rd_data_o (rd_data)
  );

  // request decode
  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign do_add   = accept && (req_type_i == REQ_ADD);
  assign do_check = accept && (req_type_i == REQ_CHECK);
  assign wrap     = (wr_ptr_q == PTR_W'(WINDOW_DEPTH - 1));

  // scan progress
  assign match      = rd_valid_q && (rd_data == key_q);
  assign issued_all = (idx_q == limit_q);
  assign issue      = (state_q == ST_SCAN) && !issued_all && !match;
  assign finish     = (state_q == ST_SCAN) && (match || (issued_all && !rd_valid_q));
  assign out_free   = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d     = state_q;
    wr_ptr_d    = wr_ptr_q;
    ring_full_d = ring_full_q;
    limit_d     = limit_q;
    idx_d       = idx_q;
    rd_valid_d  = issue;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_dup_d   = out_dup_q;
    unique case (state_q)
      ST_IDLE: begin
        if (do_add) begin
          wr_ptr_d = wrap ? '0 : wr_ptr_q + 1'b1;
          if (wrap) begin
            ring_full_d = 1'b1;
          end
        end
        if (do_check) begin
          idx_d   = '0;
          limit_d = ring_full_q ? CNT_W'(WINDOW_DEPTH) : CNT_W'(wr_ptr_q);
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          idx_d = idx_q + 1'b1;
        end
        if (finish) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_dup_d   = match;
            state_d     = ST_IDLE;
          end else begin
            res_d   = match;
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_dup_d   = res_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_ptr_q    <= '0;
      ring_full_q <= 1'b0;
      limit_q     <= '0;
      idx_q       <= '0;
      rd_valid_q  <= 1'b0;
      res_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_dup_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      ring_full_q <= ring_full_d;
      limit_q     <= limit_d;
      idx_q       <= idx_d;
      rd_valid_q  <= rd_valid_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
      out_dup_q   <= out_dup_d;
    end
  end

  // search key of the check in progress
  always_ff @(posedge clk_i) begin
    if (do_check) begin
      key_q <= msg_id_i[ID_W-1:0];
    end
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign is_duplicate_o = out_dup_q;

endmodule

// ----- sv/ridf_ring.sv -----
// identifier ring storage: one write port, one registered read port
module ridf_ring #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered: data appears the cycle after the address
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

// ----- sv/ridf_checker.sv -----
// port-level assertions of the recent-id duplicate filter, with bind
module ridf_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic req_type_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic is_duplicate_o
);
  import ridf_pkg::*;

  logic seen_add_q;
  logic in_acc;

  assign in_acc = in_valid_i && in_ready_o;

  // any add transaction since reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_add_q <= 1'b0;
    end else if (in_acc && (req_type_i == REQ_ADD)) begin
      seen_add_q <= 1'b1;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(is_duplicate_o))
    else $error("result changed while stalled");

  // an add never produces a result
  a_add_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (req_type_i == REQ_ADD) && !out_valid_o |=> !out_valid_o)
    else $error("add produced a result");

  // a check occupies the scan, so input is held off next cycle
  a_check_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (req_type_i == REQ_CHECK) |=> !in_ready_o)
    else $error("input taken during scan");

  // nothing stored yet, so no duplicate can be reported
  a_empty_no_dup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !seen_add_q |-> !is_duplicate_o)
    else $error("duplicate on empty ring");

endmodule

bind recent_id_duplicate_filter ridf_checker u_ridf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .req_type_i     (req_type_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .is_duplicate_o (is_duplicate_o)
);
